// File: hdl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation step unit.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // default grid side
    localparam int SIDE_DEF = 64;

    // operation codes of an input item
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_STEP  = 2'd3
    } t_mode;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_COPY,
        ST_HOLD
    } t_state;

    // input item
    typedef struct packed {
        t_mode      mode;
        logic [5:0] row;
        logic [5:0] col;
        logic       alive_in;
    } t_in;

    // result item
    typedef struct packed {
        logic        alive_out;
        logic [31:0] generation_count;
    } t_out;

    // controls broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic copy;
        logic clear;
    } t_cell_ctrl;

endpackage

// File: hdl/life_generation_step_unit.sv
// ----------------------------------------------------------------------------
// life_generation_step_unit
// Bounded B3/S23 life grid held in a circulating chain of cells.
// ----------------------------------------------------------------------------
// Input items (i_in_valid / o_in_stall) carry a mode: write cell, read cell,
// clear grid or step one generation. Every item gives one result item on
// o_out_valid / i_out_stall with the read bit and the generation counter.
// The grid is a ring of SIDE*SIDE cells that rotates one place per cycle in
// the shift state. Write, read: one full turn of the ring, the addressed
// cell is handled as it passes the ring end, then the hold state. Step:
// one full turn, each cell's new value taken from fixed taps around the
// center position into a second ring, then the copy state loads it, then
// the hold state. Clear: the whole ring is zeroed at acceptance, then the
// hold state. The result leaves the hold state into the output register.
// One item is worked on at a time; a new item is accepted once the result
// of the previous one sits in the output register, even while it is stalled.
// If the receiver stalls with a result still waiting, a finished item holds
// its result internally and no further item is accepted.
// Reset empties the grid, zeroes the counter and drops any result.
// ----------------------------------------------------------------------------
module life_generation_step_unit #(
    parameter int SIDE = lgs_pkg::SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lgs_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lgs_pkg::t_out o_out
);

    localparam int N  = SIDE * SIDE;
    localparam int NW = $clog2(N);
    localparam int CW = $clog2(SIDE);
    localparam int AW = (CW > 6) ? CW : 6;
    localparam int CP = SIDE + 1;

    lgs_pkg::t_state     r_state, n_state;
    lgs_pkg::t_in        r_op;
    lgs_pkg::t_cell_ctrl w_ctrl;
    logic [NW-1:0]       r_tick;
    logic [CW-1:0]       r_rc, r_cc;
    logic [31:0]         r_gen;
    logic                r_res_alive;
    logic                w_accept, w_out_free, w_match, w_head, w_new, w_last;
    logic [7:0]          w_taps;
    logic                w_cur [N];
    logic                w_nxt [N];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_last     = (r_tick == NW'(N - 1));

    // addressed cell is at the ring end
    assign w_match = (r_state == lgs_pkg::ST_SHIFT) &&
                     (AW'(r_rc) == AW'(r_op.row)) && (AW'(r_cc) == AW'(r_op.col));

    assign w_head = (w_match && r_op.mode == lgs_pkg::MODE_WRITE) ?
                    r_op.alive_in : w_cur[N-1];

    // cell ring
    for (genvar k = 0; k < N; k++) begin : g_ring
        logic w_ci, w_ni;
        if (k == 0) begin : g_head
            assign w_ci = w_head;
            assign w_ni = w_nxt[N-1];
        end else if (k == CP + 1) begin : g_inj
            assign w_ci = w_cur[k-1];
            assign w_ni = w_new;
        end else begin : g_mid
            assign w_ci = w_cur[k-1];
            assign w_ni = w_nxt[k-1];
        end
        lgs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_cur   (w_ci),
            .i_nxt   (w_ni),
            .o_cur   (w_cur[k]),
            .o_nxt   (w_nxt[k])
        );
    end

    // neighbor taps around the center position
    assign w_taps = {w_cur[0], w_cur[1], w_cur[2], w_cur[SIDE], w_cur[SIDE+2],
                     w_cur[2*SIDE], w_cur[2*SIDE+1], w_cur[2*SIDE+2]};

    lgs_rule #(.SIDE(SIDE)) u_rule (
        .i_taps  (w_taps),
        .i_row   (r_rc),
        .i_col   (r_cc),
        .i_alive (w_cur[CP]),
        .o_alive (w_new)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.mode == lgs_pkg::MODE_CLEAR) ?
                              lgs_pkg::ST_HOLD : lgs_pkg::ST_SHIFT;
                end
            end
            lgs_pkg::ST_SHIFT: begin
                if (w_last) begin
                    n_state = (r_op.mode == lgs_pkg::MODE_STEP) ?
                              lgs_pkg::ST_COPY : lgs_pkg::ST_HOLD;
                end
            end
            lgs_pkg::ST_COPY: n_state = lgs_pkg::ST_HOLD;
            lgs_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    n_state = lgs_pkg::ST_IDLE;
                end
            end
            default: n_state = lgs_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall   = (r_state != lgs_pkg::ST_IDLE);
        w_ctrl.shift = (r_state == lgs_pkg::ST_SHIFT);
        w_ctrl.copy  = (r_state == lgs_pkg::ST_COPY);
        w_ctrl.clear = w_accept && (i_in.mode == lgs_pkg::MODE_CLEAR);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgs_pkg::ST_IDLE;
            r_gen       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.clear) begin
                r_gen <= '0;
            end else if (w_ctrl.copy) begin
                r_gen <= r_gen + 32'd1;
            end
            if (r_state == lgs_pkg::ST_HOLD && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // operation, position counters and result bit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_in;
            r_tick      <= '0;
            r_res_alive <= 1'b0;
            if (i_in.mode == lgs_pkg::MODE_STEP) begin
                r_rc <= CW'(1);
                r_cc <= CW'(1);
            end else begin
                r_rc <= CW'(SIDE - 1);
                r_cc <= CW'(SIDE - 1);
            end
        end else if (r_state == lgs_pkg::ST_SHIFT) begin
            r_tick <= r_tick + NW'(1);
            if (r_cc == '0) begin
                r_cc <= CW'(SIDE - 1);
                r_rc <= (r_rc == '0) ? CW'(SIDE - 1) : r_rc - CW'(1);
            end else begin
                r_cc <= r_cc - CW'(1);
            end
            if (w_match && r_op.mode == lgs_pkg::MODE_READ) begin
                r_res_alive <= w_cur[N-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == lgs_pkg::ST_HOLD && w_out_free) begin
            o_out.alive_out        <= r_res_alive;
            o_out.generation_count <= r_gen;
        end
    end

endmodule

// File: hdl/lgs_cell.sv
// ----------------------------------------------------------------------------
// lgs_cell
// One grid cell of the circulating chain: current and next-generation bit.
// ----------------------------------------------------------------------------
module lgs_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lgs_pkg::t_cell_ctrl   i_ctrl,
    input  logic                  i_cur,
    input  logic                  i_nxt,
    output logic                  o_cur,
    output logic                  o_nxt
);

    logic r_cur;
    logic r_nxt;

    // current bit: cleared, loaded from next plane, or shifted along
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_cur <= 1'b0;
        end else if (i_ctrl.copy) begin
            r_cur <= r_nxt;
        end else if (i_ctrl.shift) begin
            r_cur <= i_cur;
        end
    end

    // next-generation bit travels with the current one
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_nxt <= i_nxt;
        end
    end

    assign o_cur = r_cur;
    assign o_nxt = r_nxt;

endmodule

// File: hdl/lgs_rule.sv
// ----------------------------------------------------------------------------
// lgs_rule
// Birth on 3, survive on 2 or 3, with neighbors off the grid edge masked.
// ----------------------------------------------------------------------------
module lgs_rule #(
    parameter int SIDE = lgs_pkg::SIDE_DEF
) (
    input  logic [7:0]              i_taps,
    input  logic [$clog2(SIDE)-1:0] i_row,
    input  logic [$clog2(SIDE)-1:0] i_col,
    input  logic                    i_alive,
    output logic                    o_alive
);

    localparam int CW = $clog2(SIDE);

    logic       w_up, w_dn, w_lf, w_rt;
    logic [7:0] w_mask;
    logic [3:0] w_cnt;

    // edge flags of the center cell
    assign w_up = (i_row != '0);
    assign w_dn = (i_row != CW'(SIDE - 1));
    assign w_lf = (i_col != '0);
    assign w_rt = (i_col != CW'(SIDE - 1));

    // tap order: upper row left to right, left, right, lower row
    assign w_mask = {w_up & w_lf, w_up, w_up & w_rt, w_lf, w_rt,
                     w_dn & w_lf, w_dn, w_dn & w_rt};

    // live neighbor count
    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < 8; k++) begin
            w_cnt = w_cnt + 4'(i_taps[k] & w_mask[k]);
        end
    end

    assign o_alive = (w_cnt == 4'd3) || ((w_cnt == 4'd2) && i_alive);

endmodule

// File: hdl/lgs_checker.sv
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the life generation step unit, bound to the top.
// ----------------------------------------------------------------------------
module lgs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input lgs_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lgs_pkg::t_out o_out
);

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // accepted item makes the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("not busy after accepting an item");

    // a new result frees the input side
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input still stalled when result appeared");

    // clear with an empty output loads a zero result via the hold state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in.mode == lgs_pkg::MODE_CLEAR && !o_out_valid)
        |=> ##1 (o_out_valid && o_out.generation_count == 32'd0 && !o_out.alive_out))
        else $error("clear result wrong");

endmodule

bind life_generation_step_unit lgs_checker u_lgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
